// File: rtl/core/mailbox_ring_queue_unit_macros.svh
// Assertion macros for the mailbox ring queue unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef MAILBOX_RING_QUEUE_UNIT_MACROS_SVH
`define MAILBOX_RING_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MRQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define MRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mrq_pkg.sv
// Shared types and codes for the mailbox ring queue unit.
// No dependencies.
`timescale 1ns / 1ps

package mrq_pkg;

	// Fixed field widths
	localparam int CAP_W  = 5;
	localparam int FILL_W = 5;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TAKE     = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD_TAIL = 2'd1;
	localparam logic [OP_W-1:0] OP_ADD_HEAD = 2'd2;
	localparam logic [OP_W-1:0] OP_FLUSH    = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Slot memory strobes from the ring control
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// Per-item result from the ring control
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              take_ok;
		logic [FILL_W-1:0] fill;
	} result_t;

endpackage

// File: rtl/core/mrq_slot_mem.sv
// Message slot storage: one write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module mrq_slot_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/mrq_ring_ctrl.sv
// Ring control: capacity, head/tail indices and fill count, plus
// per-item status and slot memory strobes. Depends on mrq_pkg.
`timescale 1ns / 1ps

module mrq_ring_ctrl #(
	parameter int SLOT_COUNT = 16,
	parameter int IDX_W      = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mrq_pkg::CAP_W-1:0]    cfg_wr_data,
	input  logic                         step,
	input  logic [mrq_pkg::OP_W-1:0]     operation,
	output mrq_pkg::mem_ctl_t            mem_ctl,
	output logic [IDX_W-1:0]             wr_addr,
	output logic [IDX_W-1:0]             rd_addr,
	output mrq_pkg::result_t             result
);

	import mrq_pkg::*;

	// Common width for index / capacity compares
	localparam int CMP_W   = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
	localparam int CAP_RST = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;

	logic [CAP_W-1:0]  cap_q;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [IDX_W-1:0]  tail_q, tail_d;
	logic [FILL_W-1:0] cnt_q, cnt_d;
	logic [CAP_W-1:0]  cap_wr;
	logic              full;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
		input logic [CAP_W-1:0] cap);
		logic [CMP_W-1:0] n;
		n = CMP_W'(i) + CMP_W'(1);
		return (n >= CMP_W'(cap)) ? '0 : n[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i,
		input logic [CAP_W-1:0] cap);
		logic [CMP_W-1:0] p;
		p = CMP_W'(cap) - CMP_W'(1);
		return (i == '0) ? p[IDX_W-1:0] : i - IDX_W'(1);
	endfunction

	// Clamp a written capacity into 1..SLOT_COUNT
	always_comb begin
		priority if (cfg_wr_data == '0) begin
			cap_wr = CAP_W'(1);
		end else if (CMP_W'(cfg_wr_data) > CMP_W'(SLOT_COUNT)) begin
			cap_wr = CAP_W'(SLOT_COUNT);
		end else begin
			cap_wr = cfg_wr_data;
		end
	end

	assign full = (CMP_W'(cnt_q) >= CMP_W'(cap_q));

	// Next state and result for the item in the input register
	always_comb begin
		head_d          = head_q;
		tail_d          = tail_q;
		cnt_d           = cnt_q;
		mem_ctl         = '0;
		wr_addr         = tail_q;
		rd_addr         = head_q;
		result.status   = ST_OK;
		result.take_ok  = 1'b0;
		unique case (operation)
			OP_TAKE: begin
				if (cnt_q == '0) begin
					result.status = ST_EMPTY;
				end else begin
					result.take_ok = 1'b1;
					mem_ctl.rd_en  = step;
					head_d         = next_idx(head_q, cap_q);
					cnt_d          = cnt_q - FILL_W'(1);
				end
			end
			OP_ADD_TAIL: begin
				if (full) begin
					result.status = ST_FULL;
				end else begin
					mem_ctl.wr_en = step;
					tail_d        = next_idx(tail_q, cap_q);
					cnt_d         = cnt_q + FILL_W'(1);
				end
			end
			OP_ADD_HEAD: begin
				if (full) begin
					result.status = ST_FULL;
				end else begin
					mem_ctl.wr_en = step;
					head_d        = prev_idx(head_q, cap_q);
					wr_addr       = head_d;
					cnt_d         = cnt_q + FILL_W'(1);
				end
			end
			OP_FLUSH: begin
				head_d = '0;
				tail_d = '0;
				cnt_d  = '0;
			end
			default: begin
				head_d = head_q;
			end
		endcase
		result.fill = cnt_d;
	end

	// State registers; a capacity write also empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_W'(CAP_RST);
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (cfg_wr_en) begin
			cap_q  <= cap_wr;
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// File: rtl/core/mailbox_ring_queue_unit.sv
// Mailbox ring queue: one operation per item, one result per item.
// Result register captures the input register's item result as the pipe advances.
// Throughput: one item per cycle; the input register, ring logic and result
// register form a two-stage pipe that only holds while the result is stalled.
// Reset: arst_n clears indices, fill count and valids, capacity returns to its default.
// Top level; depends on mrq_pkg, mrq_ring_ctrl and mrq_slot_mem.
`timescale 1ns / 1ps

module mailbox_ring_queue_unit #(
	parameter int SLOT_COUNT   = 16,
	parameter int MESSAGE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [mrq_pkg::CAP_W-1:0]     cfg_wr_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mrq_pkg::OP_W-1:0]      operation,
	input  logic [MESSAGE_BITS-1:0]       message,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mrq_pkg::STAT_W-1:0]    status,
	output logic [MESSAGE_BITS-1:0]       message_out,
	output logic [mrq_pkg::FILL_W-1:0]    fill_count
);

	import mrq_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic                    valid_s1;
	logic [OP_W-1:0]         op_s1;
	logic [MESSAGE_BITS-1:0] msg_s1;
	logic                    valid_s2;
	result_t                 res_s2;
	logic                    adv;
	logic                    step;
	mem_ctl_t                mem_ctl;
	logic [IDX_W-1:0]        wr_addr;
	logic [IDX_W-1:0]        rd_addr;
	logic [MESSAGE_BITS-1:0] rd_data;
	result_t                 result;

	// Pipe advances when the result register is empty or being taken
	assign adv      = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			msg_s1 <= message;
		end
	end

	mrq_ring_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.operation   (op_s1),
		.mem_ctl     (mem_ctl),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.result      (result)
	);

	mrq_slot_mem #(
		.DEPTH (SLOT_COUNT),
		.WIDTH (MESSAGE_BITS),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_ctl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (msg_s1),
		.rd_en   (mem_ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign fill_count  = res_s2.fill;
	assign message_out = res_s2.take_ok ? rd_data : '0;

endmodule

// File: rtl/core/mrq_checker.sv
// Port-level checker for the mailbox ring queue unit, bound to the top level.
// Depends on mrq_pkg and mailbox_ring_queue_unit_macros.svh.
`timescale 1ns / 1ps
`include "mailbox_ring_queue_unit_macros.svh"

module mrq_checker #(
	parameter int MESSAGE_BITS = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mrq_pkg::STAT_W-1:0]    status,
	input logic [MESSAGE_BITS-1:0]       message_out,
	input logic [mrq_pkg::FILL_W-1:0]    fill_count
);

	import mrq_pkg::*;

	// A stalled result holds
	`MRQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(status) && $stable(message_out) && $stable(fill_count),
		"stalled result changed")

	// Empty report only with nothing stored and no message
	`MRQ_ASSERT_NOW(a_empty_zero, out_valid && status == ST_EMPTY,
		fill_count == '0 && message_out == '0, "empty status with data")

	// Full report never with an empty ring, never with a message
	`MRQ_ASSERT_NOW(a_full_nz, out_valid && status == ST_FULL,
		fill_count != '0 && message_out == '0, "full status inconsistent")

	// A message only comes out with an ok status
	`MRQ_ASSERT_NOW(a_msg_ok, out_valid && message_out != '0, status == ST_OK,
		"message with error status")

endmodule

bind mailbox_ring_queue_unit mrq_checker #(.MESSAGE_BITS(MESSAGE_BITS)) u_mrq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.message_out (message_out),
	.fill_count  (fill_count)
);

// File: sim/tb_top.sv
// Self-checking testbench for the mailbox ring queue unit.
// Predicts each result from a local copy of the ring and checks every result.
// Depends on mrq_pkg and mailbox_ring_queue_unit.
`timescale 1ns / 1ps

module tb_top;
	import mrq_pkg::*;

	localparam int MSG_W   = 32;
	localparam int SLOTS   = 16;
	localparam int SETTLE  = 4;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [MSG_W-1:0] msg;
	} mbox_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [MSG_W-1:0]  msg;
		logic [FILL_W-1:0] fill;
	} mbox_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CAP_W-1:0]    cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     operation;
	logic [MSG_W-1:0]    message;
	logic                out_valid;
	logic                out_stall;
	logic [STAT_W-1:0]   status;
	logic [MSG_W-1:0]    message_out;
	logic [FILL_W-1:0]   fill_count;

	// Stimulus and expectation stores
	mbox_item_t   pending_items[$];
	mbox_result_t expected_results[$];

	// Shadow ring
	logic [MSG_W-1:0]  ring_slots [SLOTS];
	logic [3:0]        ring_head;
	logic [3:0]        ring_tail;
	logic [FILL_W-1:0] ring_fill;
	logic [CAP_W-1:0]  ring_cap;

	int   error_count;
	bit   item_accepted;
	bit   no_idle;
	int   send_gap;
	int   stall_left;

	mailbox_ring_queue_unit #(
		.SLOT_COUNT  (SLOTS),
		.MESSAGE_BITS(MSG_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.message    (message),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.message_out(message_out),
		.fill_count (fill_count)
	);

	// Clock, 8 ns period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Index wrap helpers
	function automatic logic [3:0] ring_next(input logic [3:0] idx);
		logic [4:0] n;
		n = {1'b0, idx} + 5'd1;
		return (n >= ring_cap) ? 4'd0 : n[3:0];
	endfunction

	function automatic logic [3:0] ring_prev(input logic [3:0] idx);
		return (idx == 4'd0) ? 4'(ring_cap - 5'd1) : idx - 4'd1;
	endfunction

	function automatic void ring_clear();
		ring_head = '0;
		ring_tail = '0;
		ring_fill = '0;
	endfunction

	// Capacity write: clamp to 1..SLOTS, empties the ring
	function automatic void ring_set_capacity(input logic [CAP_W-1:0] value);
		if (value == '0)
			ring_cap = 5'd1;
		else if (value > SLOTS)
			ring_cap = 5'(SLOTS);
		else
			ring_cap = value;
		ring_clear();
	endfunction

	// Apply one operation to the shadow ring and queue its result
	function automatic void mailbox_step(input logic [OP_W-1:0] op,
			input logic [MSG_W-1:0] msg);
		mbox_result_t r;
		r.status = ST_OK;
		r.msg    = '0;
		case (op)
			OP_TAKE: begin
				if (ring_fill == '0) begin
					r.status = ST_EMPTY;
				end else begin
					r.msg     = ring_slots[ring_head];
					ring_head = ring_next(ring_head);
					ring_fill = ring_fill - 5'd1;
				end
			end
			OP_ADD_TAIL: begin
				if (ring_fill >= ring_cap) begin
					r.status = ST_FULL;
				end else begin
					ring_slots[ring_tail] = msg;
					ring_tail = ring_next(ring_tail);
					ring_fill = ring_fill + 5'd1;
				end
			end
			OP_ADD_HEAD: begin
				if (ring_fill >= ring_cap) begin
					r.status = ST_FULL;
				end else begin
					ring_head = ring_prev(ring_head);
					ring_slots[ring_head] = msg;
					ring_fill = ring_fill + 5'd1;
				end
			end
			default: ring_clear();
		endcase
		r.fill = ring_fill;
		expected_results.push_back(r);
	endfunction

	task automatic report_mismatch(input string field, input logic [MSG_W-1:0] exp_val,
			input logic [MSG_W-1:0] act_val);
		error_count++;
		$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_val,
			act_val);
	endtask

	// Acceptance, prediction and result checking at the rising edge
	always @(posedge clk) begin
		mbox_result_t exp_r;
		if (!arst_n) begin
			item_accepted = 1'b0;
		end else begin
			item_accepted = in_valid && !in_stall;
			if (item_accepted)
				mailbox_step(operation, message);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display({"%0t ns: unexpected result, expected none, ",
						"actual status %0d msg 0x%0h fill %0d"},
						$time, status, message_out, fill_count);
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.status)
						report_mismatch("status", MSG_W'(exp_r.status), MSG_W'(status));
					if (message_out !== exp_r.msg)
						report_mismatch("message_out", exp_r.msg, message_out);
					if (fill_count !== exp_r.fill)
						report_mismatch("fill_count", MSG_W'(exp_r.fill),
							MSG_W'(fill_count));
				end
			end
		end
	end

	// Item driver: holds a stalled item, inserts random gap bursts
	always @(negedge clk) begin
		mbox_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !item_accepted) begin
			// stalled, keep item
		end else if (send_gap > 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (!no_idle && pending_items.size() != 0 && $urandom_range(0, 7) == 0) begin
			send_gap = $urandom_range(1, 9) - 1;
			in_valid <= 1'b0;
		end else if (pending_items.size() != 0) begin
			nxt = pending_items.pop_front();
			in_valid  <= 1'b1;
			operation <= nxt.op;
			message   <= nxt.msg;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result stall bursts
	always @(negedge clk) begin
		if (!arst_n || no_idle) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic queue_op(input logic [OP_W-1:0] op, input logic [MSG_W-1:0] msg);
		mbox_item_t it;
		it.op  = op;
		it.msg = msg;
		pending_items.push_back(it);
	endtask

	// Random ops in runs that lean toward filling or draining the ring
	task automatic queue_random_ops(input int count);
		int run_left;
		bit fill_mode;
		int pick;
		logic [OP_W-1:0]  op;
		logic [MSG_W-1:0] msg;
		run_left  = 0;
		fill_mode = 1'b1;
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				run_left  = $urandom_range(3, 24);
				fill_mode = 1'($urandom_range(0, 1));
			end
			run_left--;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = OP_FLUSH;
			else if (fill_mode)
				op = (pick < 48) ? OP_ADD_TAIL : (pick < 73) ? OP_ADD_HEAD : OP_TAKE;
			else
				op = (pick < 73) ? OP_TAKE : (pick < 87) ? OP_ADD_TAIL : OP_ADD_HEAD;
			case ($urandom_range(0, 15))
				0:       msg = '0;
				1:       msg = '1;
				default: msg = $urandom;
			endcase
			queue_op(op, msg);
		end
	endtask

	// Wait until every queued item is sent and every result is back
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		ring_set_capacity(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Timeout
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Phases
	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		operation   = OP_TAKE;
		message     = '0;
		out_stall   = 1'b0;
		error_count = 0;
		no_idle     = 1'b0;
		send_gap    = 0;
		stall_left  = 0;
		item_accepted = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			ring_slots[i] = '0;
		ring_cap = 5'(SLOTS);
		ring_clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default capacity: empty take, field extremes, head add wrapping at index 0
		queue_op(OP_TAKE, 32'h1234_5678);
		queue_op(OP_ADD_TAIL, '0);
		queue_op(OP_ADD_TAIL, '1);
		queue_op(OP_ADD_HEAD, 32'hA5A5_A5A5);
		queue_op(OP_TAKE, '0);
		queue_op(OP_TAKE, '1);
		queue_op(OP_TAKE, '0);
		queue_op(OP_TAKE, '0);
		queue_op(OP_FLUSH, '1);
		queue_op(OP_ADD_TAIL, 32'h5A5A_5A5A);
		queue_op(OP_FLUSH, '0);
		wait_drained();

		// Small ring: full on both adds, drain past empty, flush with data
		set_capacity(5'd3);
		queue_op(OP_ADD_HEAD, 32'h0000_0001);
		queue_op(OP_ADD_TAIL, 32'h0000_0002);
		queue_op(OP_ADD_TAIL, 32'h8000_0000);
		queue_op(OP_ADD_TAIL, 32'hDEAD_BEEF);
		queue_op(OP_ADD_HEAD, 32'hCAFE_F00D);
		queue_op(OP_TAKE, '0);
		queue_op(OP_TAKE, '0);
		queue_op(OP_TAKE, '0);
		queue_op(OP_TAKE, '0);
		queue_op(OP_ADD_TAIL, 32'h7FFF_FFFF);
		queue_op(OP_FLUSH, '0);
		queue_op(OP_TAKE, '0);
		wait_drained();

		// Zero capacity acts as one slot
		set_capacity(5'd0);
		queue_random_ops(60);
		wait_drained();

		// Oversize capacity clamps to the slot count; sender waits for all results midway
		set_capacity(5'd31);
		queue_random_ops(125);
		wait_drained();
		queue_random_ops(125);
		wait_drained();

		set_capacity(5'd17);
		queue_random_ops(80);
		wait_drained();

		set_capacity(5'd2);
		queue_random_ops(100);
		wait_drained();

		set_capacity(5'd1);
		queue_random_ops(60);
		wait_drained();

		for (int k = 0; k < 2; k++) begin
			set_capacity(5'($urandom_range(3, 15)));
			queue_random_ops(150);
			wait_drained();
		end

		// Full capacity at full rate, no gaps or stalls
		no_idle = 1'b1;
		set_capacity(5'(SLOTS));
		queue_random_ops(150);
		wait_drained();
		repeat (8) @(posedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
